// File: rtl/lgcs_pkg.sv
// Package for the Lehmer GCD cofactor step unit.
// Holds the sequencer state type and the word and loop constants.
// It depends on nothing else.
package lgcs_pkg;

   localparam int WORD_BITS  = 32;
   localparam int STEP_LIMIT = 128;
   localparam int CNT_BITS   = $clog2(STEP_LIMIT + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_NORM,
      S_CHECK,
      S_DIV,
      S_DIVEND,
      S_MULW,
      S_MULD,
      S_MULC,
      S_MULV,
      S_APPLY,
      S_DONE
   } state_type;

endpackage

// File: rtl/lehmer_gcd_cofactor_step_unit.sv
// Top level of the Lehmer GCD cofactor step unit.
// It computes one Lehmer cofactor matrix per request word.
// It depends on lgcs_pkg.
//
// A request word carries the top three words of U and V, the length class
// of U and the flag that V is shorter. The unit takes a request only while
// it is idle; req_stall is high from acceptance until the response word has
// been loaded into the output register. Each response word carries the
// cofactors A, B, C and D, the step parity and the progress flag.
// Each quotient step uses a restoring divider that retires one quotient bit
// a cycle and a shift-add multiplier that retires one multiplier bit a
// cycle and stops when the remaining bits are zero (run up to four times
// per step). Three-word numbers are normalized before the first step.
// The response waits in its register while rsp_stall is high; the next
// request is taken once it has been loaded. Synchronous reset returns the
// sequencer to idle and drops rsp_valid.
module lehmer_gcd_cofactor_step_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_u_hi,
   input  logic [31:0] req_u_mid,
   input  logic [31:0] req_u_lo,
   input  logic [31:0] req_v_hi,
   input  logic [31:0] req_v_mid,
   input  logic [31:0] req_v_lo,
   input  logic [1:0]  req_len_class,
   input  logic        req_v_shorter,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_coef_a,
   output logic [31:0] rsp_coef_b,
   output logic [31:0] rsp_coef_c,
   output logic [31:0] rsp_coef_d,
   output logic        rsp_odd_parity,
   output logic        rsp_made_progress
);
   import lgcs_pkg::*;

   state_type state_ff, state_in;
   logic [63:0] u_ff, u_in, v_ff, v_in;
   logic [63:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic        odd_ff, odd_in, long_ff, long_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [95:0] nu_ff, nu_in, nv_ff, nv_in;
   logic [63:0] den_ff, den_in, rem_ff, rem_in, quo_ff, quo_in;
   logic [5:0]  dcnt_ff, dcnt_in;
   logic [63:0] q_ff, q_in, w_ff, w_in, nd_ff, nd_in, nc_ff, nc_in, nv2_ff, nv2_in;
   logic [63:0] acc_ff, acc_in, mx_ff, mx_in, my_ff, my_in;
   logic        rv_ff, rv_in;
   logic [31:0] ra_ff, ra_in, rb_ff, rb_in, rc_ff, rc_in, rd_ff, rd_in;
   logic        ro_ff, ro_in;

   logic [63:0] sub_w, add_w, csub_w, cadd_w, den_w;
   logic [64:0] trial_w, sum_w;
   logic [63:0] vh_w;
   logic        ovf_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
      u_ff <= u_in;   v_ff <= v_in;
      a_ff <= a_in;   b_ff <= b_in;   c_ff <= c_in;   d_ff <= d_in;
      odd_ff <= odd_in;  long_ff <= long_in;  cnt_ff <= cnt_in;
      nu_ff <= nu_in; nv_ff <= nv_in;
      den_ff <= den_in; rem_ff <= rem_in; quo_ff <= quo_in; dcnt_ff <= dcnt_in;
      q_ff <= q_in;   w_ff <= w_in;   nd_ff <= nd_in; nc_ff <= nc_in; nv2_ff <= nv2_in;
      acc_ff <= acc_in; mx_ff <= mx_in; my_ff <= my_in;
      ra_ff <= ra_in; rb_ff <= rb_in; rc_ff <= rc_in; rd_ff <= rd_in; ro_ff <= ro_in;
   end

   always_comb begin
      if (odd_ff == 1'b0) begin
         sub_w = b_ff; add_w = d_ff; csub_w = c_ff; cadd_w = a_ff;
      end else begin
         sub_w = a_ff; add_w = c_ff; csub_w = d_ff; cadd_w = b_ff;
      end
      den_w   = v_ff + add_w;
      trial_w = {rem_ff, quo_ff[63]} - {1'b0, den_ff};
      sum_w   = {1'b0, acc_ff} + {1'b0, b_ff};
      if (d_ff == 64'd0) begin
         ovf_w = (b_ff[63:32] != 32'd0);
      end else if (q_ff[63:32] != 32'd0) begin
         ovf_w = 1'b1;
      end else begin
         ovf_w = (sum_w[64:32] != 33'd0);
      end
      vh_w = {32'd0, req_v_shorter ? 32'd0 : req_v_hi};
   end

   always_comb begin
      state_in = state_ff;
      u_in = u_ff;   v_in = v_ff;
      a_in = a_ff;   b_in = b_ff;   c_in = c_ff;   d_in = d_ff;
      odd_in = odd_ff;  long_in = long_ff;  cnt_in = cnt_ff;
      nu_in = nu_ff; nv_in = nv_ff;
      den_in = den_ff; rem_in = rem_ff; quo_in = quo_ff; dcnt_in = dcnt_ff;
      q_in = q_ff;   w_in = w_ff;   nd_in = nd_ff; nc_in = nc_ff; nv2_in = nv2_ff;
      acc_in = acc_ff; mx_in = mx_ff; my_in = my_ff;
      rv_in = rv_ff;
      ra_in = ra_ff; rb_in = rb_ff; rc_in = rc_ff; rd_in = rd_ff; ro_in = ro_ff;
      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               a_in = 64'd1; b_in = 64'd0; c_in = 64'd0; d_in = 64'd1;
               odd_in = 1'b0;
               cnt_in = '0;
               if (req_len_class == 2'd3) begin
                  long_in  = 1'b1;
                  nu_in    = {req_u_hi, req_u_mid, req_u_lo};
                  nv_in    = {vh_w[31:0], req_v_mid, req_v_lo};
                  state_in = S_NORM;
               end else if (req_len_class == 2'd2) begin
                  long_in  = 1'b0;
                  u_in     = {req_u_hi, req_u_mid};
                  v_in     = {vh_w[31:0], req_v_mid};
                  state_in = S_CHECK;
               end else begin
                  long_in  = 1'b0;
                  u_in     = {32'd0, req_u_hi};
                  v_in     = vh_w;
                  state_in = S_CHECK;
               end
            end
         end
         S_NORM: begin
            if (nu_ff[95] || nu_ff[95:32] == 64'd0) begin
               u_in     = {1'b0, nu_ff[95:33]};
               v_in     = {1'b0, nv_ff[95:33]};
               state_in = S_CHECK;
            end else begin
               nu_in = {nu_ff[94:0], 1'b0};
               nv_in = {nv_ff[94:0], 1'b0};
            end
         end
         S_CHECK: begin
            rem_in  = 64'd0;
            dcnt_in = '0;
            if (cnt_ff == CNT_BITS'(STEP_LIMIT)) begin
               state_in = S_DONE;
            end else if (!long_ff) begin
               if (v_ff == 64'd0) begin
                  state_in = S_DONE;
               end else begin
                  den_in   = v_ff;
                  quo_in   = u_ff;
                  state_in = S_DIV;
               end
            end else if (den_w == 64'd0) begin
               state_in = S_DONE;
            end else begin
               den_in   = den_w;
               quo_in   = u_ff - sub_w;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!trial_w[64]) begin
               rem_in = trial_w[63:0];
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = {rem_ff[62:0], quo_ff[63]};
               quo_in = {quo_ff[62:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 6'd1;
            if (dcnt_ff == 6'd63) begin
               state_in = S_DIVEND;
            end
         end
         S_DIVEND: begin
            q_in   = quo_ff;
            acc_in = 64'd0;
            mx_in  = quo_ff;
            if (!long_ff) begin
               my_in    = d_ff;
               state_in = S_MULD;
            end else if (v_ff < csub_w) begin
               state_in = S_DONE;
            end else begin
               w_in     = v_ff - csub_w;
               my_in    = v_ff - csub_w;
               state_in = S_MULW;
            end
         end
         S_MULW, S_MULD, S_MULC, S_MULV: begin
            if (my_ff != 64'd0) begin
               if (my_ff[0]) begin
                  acc_in = acc_ff + mx_ff;
               end
               mx_in = {mx_ff[62:0], 1'b0};
               my_in = {1'b0, my_ff[63:1]};
            end else begin
               acc_in = 64'd0;
               mx_in  = q_ff;
               case (state_ff)
                  S_MULW: begin
                     if (u_ff + cadd_w >= acc_ff + w_ff) begin
                        state_in = S_DONE;
                     end else begin
                        my_in    = d_ff;
                        state_in = S_MULD;
                     end
                  end
                  S_MULD: begin
                     if (ovf_w) begin
                        state_in = S_DONE;
                     end else begin
                        nd_in    = sum_w[63:0];
                        my_in    = c_ff;
                        state_in = S_MULC;
                     end
                  end
                  S_MULC: begin
                     nc_in    = a_ff + acc_ff;
                     my_in    = v_ff;
                     state_in = S_MULV;
                  end
                  default: begin
                     nv2_in   = u_ff - acc_ff;
                     state_in = S_APPLY;
                  end
               endcase
            end
         end
         S_APPLY: begin
            b_in = d_ff;  d_in = nd_ff;
            a_in = c_ff;  c_in = nc_ff;
            u_in = v_ff;  v_in = nv2_ff;
            odd_in   = ~odd_ff;
            cnt_in   = cnt_ff + CNT_BITS'(1);
            state_in = S_CHECK;
         end
         S_DONE: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in    = 1'b1;
               ra_in    = a_ff[31:0];
               rb_in    = b_ff[31:0];
               rc_in    = c_ff[31:0];
               rd_in    = d_ff[31:0];
               ro_in    = odd_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rv_ff;
   assign rsp_coef_a        = ra_ff;
   assign rsp_coef_b        = rb_ff;
   assign rsp_coef_c        = rc_ff;
   assign rsp_coef_d        = rd_ff;
   assign rsp_odd_parity    = ro_ff;
   assign rsp_made_progress = (rb_ff != 32'd0);

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> cnt_ff <= CNT_BITS'(STEP_LIMIT))
      else $error("step count beyond limit");
   a_apply_toggles: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_APPLY |=> odd_ff != $past(odd_ff))
      else $error("parity did not toggle on a step");
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && dcnt_ff == 6'd63) |=> state_ff == S_DIVEND)
      else $error("divider did not finish after 64 bits");
   a_done_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !(rv_ff && rsp_stall)) |=> (rv_ff && state_ff == S_IDLE))
      else $error("result word not loaded");

endmodule
